@@ design/sdf_pkg.sv @@
// shared types and constants for the stream distinct filter
// depends on nothing; used by the cell, the top level and the checker
package sdf_pkg;

    // number of table entries, one per cell
    localparam int TABLE_DEPTH = 64;
    // width of the stored-entry count, holds 0 .. TABLE_DEPTH
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int DCNT_W = 7;

    // request traveling down the cell chain
    typedef struct packed {
        logic             act;   // a request occupies this slot
        logic             hit;   // value matched a stored entry
        logic             wr;    // value was written into a free cell
        logic [CNT_W-1:0] rem;   // valid entries left ahead of this cell
        logic [VAL_W-1:0] val;   // value being looked up
    } token_t;

endpackage

@@ design/stream_distinct_filter.sv @@
// top level of the stream distinct filter: request entry, cell chain, result
// registers and the stored-entry count; uses sdf_pkg and sdf_cell
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  request  | start in, busy out        | value, last_item
//  result   | done out (one-cycle pulse)| value_out, is_new, distinct_count,
//           |                           | table_full, last_out
//
// a request walks the chain one cell per cycle; busy stays high while it is in
// the chain, so a new request is taken only after the last one has left it;
// the next start is taken in the cycle done is shown. reset empties the table
// at once; the result receiver cannot stall, each result shows for exactly
// one cycle.
module stream_distinct_filter
    import sdf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [VAL_W-1:0] value,
    input  logic                    last_item,
    output logic                    done,
    output logic signed [VAL_W-1:0] value_out,
    output logic                    is_new,
    output logic [DCNT_W-1:0]       distinct_count,
    output logic                    table_full,
    output logic                    last_out
);

    token_t            chain [TABLE_DEPTH+1];
    token_t            tail;
    logic              accept;
    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  count_after;
    logic              last_reg;
    logic              done_reg;
    logic [VAL_W-1:0]  value_out_reg;
    logic              is_new_reg;
    logic [DCNT_W-1:0] dcount_reg;
    logic              full_reg;
    logic              last_out_reg;

    assign accept = start && !busy_reg;

    // request entering the first cell
    always_comb
    begin
        chain[0]     = '0;
        chain[0].act = accept;
        chain[0].rem = count_reg;
        chain[0].val = value;
    end

    // cell chain
    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        sdf_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    assign tail        = chain[TABLE_DEPTH];
    assign count_after = count_reg + CNT_W'(tail.wr);

    // busy and count control
    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (tail.act)
        begin
            busy_next  = 1'b0;
            count_next = last_reg ? '0 : count_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            done_reg  <= tail.act;
        end
    end

    // end-of-list flag of the request in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_item;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (tail.act)
        begin
            value_out_reg <= tail.val;
            is_new_reg    <= !tail.hit;
            full_reg      <= !tail.hit && !tail.wr;
            dcount_reg    <= DCNT_W'(count_after);
            last_out_reg  <= last_reg;
        end
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign value_out      = value_out_reg;
    assign is_new         = is_new_reg;
    assign distinct_count = dcount_reg;
    assign table_full     = full_reg;
    assign last_out       = last_out_reg;

endmodule

@@ design/sdf_cell.sv @@
// one table cell: holds one entry, compares the passing request with it,
// takes the value if it is the first free cell; uses sdf_pkg
module sdf_cell
    import sdf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  token_t tok_in,
    output token_t tok_out
);

    token_t           tok_reg;
    token_t           tok_next;
    logic [VAL_W-1:0] entry_reg;
    logic             in_range;
    logic             match;
    logic             take;

    // entry is live when there are valid entries left at this position
    assign in_range = (tok_in.rem != '0);
    assign match    = tok_in.act && in_range && (entry_reg == tok_in.val);
    // first free cell takes a value that was not found
    assign take     = tok_in.act && !in_range && !tok_in.hit && !tok_in.wr;

    // next request slot
    always_comb
    begin
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit || match;
        tok_next.wr  = tok_in.wr || take;
        tok_next.rem = in_range ? (tok_in.rem - 1'b1) : '0;
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // stored entry
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg <= tok_in.val;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ design/sdf_checker.sv @@
// port-level checks for the stream distinct filter, bound to the top level
// uses sdf_pkg and the ports of stream_distinct_filter
module sdf_checker
    import sdf_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic                    is_new,
    input logic                    table_full,
    input logic [DCNT_W-1:0]       distinct_count
);

    // an accepted request keeps the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");

    // results never come in adjacent cycles
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // the block is free while a result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while result shown");

    // a dropped value is always a new one
    a_full_new: assert property (@(posedge clk) disable iff (!rst_n)
        done && table_full |-> is_new && (distinct_count == DCNT_W'(TABLE_DEPTH)))
        else $error("table full flag inconsistent");

endmodule

bind stream_distinct_filter sdf_checker u_sdf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .is_new         (is_new),
    .table_full     (table_full),
    .distinct_count (distinct_count)
);
